// File: rtl/wma_pkg.sv
// wma_pkg: shared constants and types for the wearable minute aggregator
// no dependencies
`default_nettype none
package wma_pkg;
	localparam int DEVICES_DEF = 16;
	localparam int DEV_W = 4;
	localparam int SUM_W = 24;
	localparam int CNT_W = 16;
	localparam logic [7:0] STEP_LIMIT_RESET = 8'd20;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// one device record
	typedef struct packed {
		logic open;
		logic [31:0] minute;
		logic mapped;
		logic [15:0] resident;
		logic prev_valid;
		logic [15:0] prev_count;
		logic [SUM_W-1:0] steps;
		logic [SUM_W-1:0] hsum;
		logic [CNT_W-1:0] hcnt;
		logic [SUM_W-1:0] osum;
		logic [CNT_W-1:0] ocnt;
	} rec_t;
endpackage
`default_nettype wire

// File: rtl/wma_div.sv
// wma_div: shared restoring divider, one quotient bit per cycle, mean clamped to 255
// depends on wma_pkg
`default_nettype none
module wma_div
	import wma_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [SUM_W-1:0] dividend,
	input wire logic [CNT_W-1:0] divisor,
	output logic done,
	output logic [7:0] mean
);
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;

	assign trial = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[CNT_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	// zero divisor gives zero, else clamp
	always_comb begin
		if (dvs_q == '0) mean = 8'd0;
		else if (quo_q[SUM_W-1:8] != '0) mean = 8'hFF;
		else mean = quo_q[7:0];
	end
endmodule
`default_nettype wire

// File: rtl/wearable_minute_aggregator.sv
// wearable_minute_aggregator: top level, device record file, sequencer, output register
// depends on wma_pkg and wma_div
//
// channel   direction  handshake                payload
// in        input      in_valid / in_ready      operation .. resident_number
// out       output     out_valid / out_ready    out_device .. last
// cfg       input      cfg_we                   cfg_data (max_steps_per_sample)
//
// a sample that closes no minute goes through check and update; one that emits a record goes through
// check, two serial divisions on the one shared divider, output, update
// a flush visits every device in turn through check, update and next, plus divisions and output per record emitted
// reset clears all device records at once (flip-flops)
// while an earlier record still waits on out_ready the sequencer holds in its output step;
// in_ready is low from acceptance until the request is finished
`default_nettype none
module wearable_minute_aggregator
	import wma_pkg::*;
#(
	parameter int DEVICES = DEVICES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic operation,
	input wire logic [DEV_W-1:0] device,
	input wire logic [31:0] minute_number,
	input wire logic [15:0] cumulative_steps,
	input wire logic [7:0] pulse_bpm,
	input wire logic [7:0] oxygen_saturation,
	input wire logic resident_known,
	input wire logic [15:0] resident_number,
	output logic out_valid,
	input wire logic out_ready,
	output logic [DEV_W-1:0] out_device,
	output logic [15:0] out_resident,
	output logic [31:0] out_minute,
	output logic [SUM_W-1:0] steps_in_minute,
	output logic [15:0] last_cumulative,
	output logic [7:0] avg_heart_rate,
	output logic [7:0] avg_oxygen,
	output logic last,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_data
);
	localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
	localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_DIVH = 3'd2,
		S_DIVO = 3'd3, S_OUT = 3'd4, S_UPD = 3'd5, S_NEXT = 3'd6;

	rec_t recs_q [DEVICES];
	logic [7:0] max_q;
	logic [2:0] state_q;
	logic flush_q;
	logic [IDX_W-1:0] idx_q;
	// request fields held while the item is worked on
	logic [31:0] min_q;
	logic [15:0] stp_q, res_q;
	logic [7:0] hr_q, ox_q;
	logic known_q;
	logic [7:0] avgh_q;
	rec_t cur;
	logic div_start, div_done;
	logic [SUM_W-1:0] div_a;
	logic [CNT_W-1:0] div_b;
	logic [7:0] div_mean;
	logic close_now, more;
	logic emit;
	logic later_rec;

	assign cur = recs_q[idx_q];
	assign in_ready = (state_q == S_IDLE);
	// sample closes when minute differs; flush closes any open record
	assign close_now = cur.open && (flush_q || cur.minute != min_q);
	assign more = flush_q && (idx_q != IDX_W'(DEVICES - 1));
	// output register free for a new record
	assign emit = (state_q == S_OUT) && (!out_valid || out_ready);

	// any device past the current one that a flush will still report
	always_comb begin
		later_rec = 1'b0;
		for (int j = 0; j < DEVICES; j++)
			if (j > int'(idx_q) && recs_q[j].open && recs_q[j].mapped) later_rec = 1'b1;
	end

	wma_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .mean(div_mean)
	);
	assign div_start = (state_q == S_CHECK && close_now && cur.mapped)
		|| (state_q == S_DIVH && div_done);
	assign div_a = (state_q == S_CHECK) ? cur.hsum : cur.osum;
	assign div_b = (state_q == S_CHECK) ? cur.hcnt : cur.ocnt;

	// sample update: step increase, clamp, saturating sums
	function automatic rec_t apply(rec_t r, logic [31:0] m, logic [15:0] s,
		logic [7:0] h, logic [7:0] o, logic k, logic [15:0] res, logic [7:0] mx);
		rec_t t;
		logic [16:0] inc;
		logic [SUM_W:0] sum;
		t = r;
		if (!t.open) begin
			t.open = 1'b1; t.minute = m; t.mapped = k; t.resident = res;
		end
		if (t.prev_valid) begin
			inc = (s >= t.prev_count) ? {1'b0, s - t.prev_count} : 17'd0;
			if (inc > {9'd0, mx}) inc = {9'd0, mx};
			sum = {1'b0, t.steps} + (SUM_W+1)'(inc);
			t.steps = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
		end
		t.prev_valid = 1'b1;
		t.prev_count = s;
		if (h != 8'd0) begin
			sum = {1'b0, t.hsum} + (SUM_W+1)'(h);
			t.hsum = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
			if (t.hcnt != CNT_MAX) t.hcnt = t.hcnt + 1'b1;
		end
		if (o != 8'd0) begin
			sum = {1'b0, t.osum} + (SUM_W+1)'(o);
			t.osum = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
			if (t.ocnt != CNT_MAX) t.ocnt = t.ocnt + 1'b1;
		end
		return t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_q <= STEP_LIMIT_RESET;
			out_valid <= 1'b0;
			flush_q <= 1'b0;
			idx_q <= '0;
			for (int i = 0; i < DEVICES; i++) recs_q[i] <= '0;
		end else begin
			if (cfg_we) max_q <= cfg_data;
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					flush_q <= (operation == OP_FLUSH);
					if (operation == OP_FLUSH) begin
						idx_q <= '0;
						state_q <= S_CHECK;
					end else if ({{(32-DEV_W){1'b0}}, device} < 32'(DEVICES)) begin
						idx_q <= IDX_W'(device);
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (close_now && cur.mapped) state_q <= S_DIVH;
					else begin
						if (close_now) begin
							recs_q[idx_q].open <= 1'b0;
							recs_q[idx_q].steps <= '0;
							recs_q[idx_q].hsum <= '0;
							recs_q[idx_q].hcnt <= '0;
							recs_q[idx_q].osum <= '0;
							recs_q[idx_q].ocnt <= '0;
						end
						state_q <= S_UPD;
					end
				end
				S_DIVH: if (div_done) begin
					avgh_q <= div_mean;
					state_q <= S_DIVO;
				end
				S_DIVO: if (div_done) state_q <= S_OUT;
				S_OUT: if (emit) begin
					out_device <= DEV_W'(idx_q);
					out_resident <= cur.resident;
					out_minute <= cur.minute;
					steps_in_minute <= cur.steps;
					last_cumulative <= cur.prev_count;
					avg_heart_rate <= avgh_q;
					avg_oxygen <= div_mean;
					// a flush marks the record after which no mapped device remains open
					last <= !flush_q || !later_rec;
					recs_q[idx_q].open <= 1'b0;
					recs_q[idx_q].steps <= '0;
					recs_q[idx_q].hsum <= '0;
					recs_q[idx_q].hcnt <= '0;
					recs_q[idx_q].osum <= '0;
					recs_q[idx_q].ocnt <= '0;
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (!flush_q) begin
						recs_q[idx_q] <= apply(cur, min_q, stp_q, hr_q, ox_q, known_q,
							res_q, max_q);
						state_q <= S_IDLE;
					end else state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (more) begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_CHECK;
					end else state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			min_q <= minute_number;
			stp_q <= cumulative_steps;
			hr_q <= pulse_bpm;
			ox_q <= oxygen_saturation;
			known_q <= resident_known;
			res_q <= resident_number;
		end
	end
endmodule
`default_nettype wire

// File: test/tb.sv
// tb: self-checking testbench for wearable_minute_aggregator
// depends on wma_pkg and the aggregator rtl; predicts minute records and checks them in order
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import wma_pkg::*;

	// one sample or flush request
	typedef struct packed {
		logic op;
		logic [3:0] dev;
		logic [31:0] minute;
		logic [15:0] steps;
		logic [7:0] hr;
		logic [7:0] spo2;
		logic known;
		logic [15:0] resident;
	} req_t;

	// one emitted minute record
	typedef struct packed {
		logic [3:0] dev;
		logic [15:0] resident;
		logic [31:0] minute;
		logic [23:0] steps;
		logic [15:0] end_count;
		logic [7:0] avg_hr;
		logic [7:0] avg_ox;
		logic last;
	} minrec_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic operation, resident_known, last, cfg_we;
	logic [3:0] device, out_device;
	logic [31:0] minute_number, out_minute;
	logic [15:0] cumulative_steps, resident_number, out_resident, last_cumulative;
	logic [7:0] pulse_bpm, oxygen_saturation, avg_heart_rate, avg_oxygen, cfg_data;
	logic [23:0] steps_in_minute;

	wearable_minute_aggregator i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .device(device), .minute_number(minute_number),
		.cumulative_steps(cumulative_steps), .pulse_bpm(pulse_bpm),
		.oxygen_saturation(oxygen_saturation), .resident_known(resident_known),
		.resident_number(resident_number),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_device(out_device), .out_resident(out_resident), .out_minute(out_minute),
		.steps_in_minute(steps_in_minute), .last_cumulative(last_cumulative),
		.avg_heart_rate(avg_heart_rate), .avg_oxygen(avg_oxygen), .last(last),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// predictor copy of the per-device records and the step limit
	rec_t dev_state [16];
	logic [7:0] step_limit;

	req_t pending_reqs [$];
	minrec_t expected_records [$];
	int errors = 0;
	int accepted = 0;
	int queued = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] trunc_mean(logic [23:0] sum, logic [15:0] n);
		logic [23:0] m;
		if (n == 0) return 8'd0;
		m = sum / n;
		return (m > 24'd255) ? 8'd255 : m[7:0];
	endfunction

	function automatic logic [23:0] add_sat(logic [23:0] a, logic [23:0] b, logic [23:0] lim);
		logic [24:0] s;
		s = a + b;
		return (s > lim) ? lim : s[23:0];
	endfunction

	// closes the open minute of one device, queuing a record if it was mapped
	function automatic bit close_minute(int d);
		minrec_t r;
		bit hit;
		hit = 0;
		if (!dev_state[d].open) return 0;
		if (dev_state[d].mapped) begin
			r.dev = d[3:0];
			r.resident = dev_state[d].resident;
			r.minute = dev_state[d].minute;
			r.steps = dev_state[d].steps;
			r.end_count = dev_state[d].prev_count;
			r.avg_hr = trunc_mean(dev_state[d].hsum, dev_state[d].hcnt);
			r.avg_ox = trunc_mean(dev_state[d].osum, dev_state[d].ocnt);
			r.last = 1'b0;
			expected_records.push_back(r);
			hit = 1;
		end
		dev_state[d].steps = '0;
		dev_state[d].hsum = '0;
		dev_state[d].hcnt = '0;
		dev_state[d].osum = '0;
		dev_state[d].ocnt = '0;
		dev_state[d].open = 1'b0;
		return hit;
	endfunction

	task automatic predict_minute_records(req_t q);
		int n;
		logic [15:0] inc;
		n = 0;
		if (q.op == OP_FLUSH) begin
			for (int d = 0; d < 16; d++) n += close_minute(d);
		end else begin
			if (dev_state[q.dev].open && dev_state[q.dev].minute != q.minute)
				n += close_minute(q.dev);
			if (!dev_state[q.dev].open) begin
				dev_state[q.dev].open = 1'b1;
				dev_state[q.dev].minute = q.minute;
				dev_state[q.dev].mapped = q.known;
				dev_state[q.dev].resident = q.resident;
			end
			if (dev_state[q.dev].prev_valid) begin
				inc = 0;
				if (q.steps >= dev_state[q.dev].prev_count) begin
					inc = q.steps - dev_state[q.dev].prev_count;
					if (inc > step_limit) inc = step_limit;
				end
				dev_state[q.dev].steps = add_sat(dev_state[q.dev].steps, inc, SUM_MAX);
			end
			dev_state[q.dev].prev_valid = 1'b1;
			dev_state[q.dev].prev_count = q.steps;
			if (q.hr != 0) begin
				dev_state[q.dev].hsum = add_sat(dev_state[q.dev].hsum, q.hr, SUM_MAX);
				dev_state[q.dev].hcnt = 16'(add_sat(dev_state[q.dev].hcnt, 24'd1, CNT_MAX));
			end
			if (q.spo2 != 0) begin
				dev_state[q.dev].osum = add_sat(dev_state[q.dev].osum, q.spo2, SUM_MAX);
				dev_state[q.dev].ocnt = 16'(add_sat(dev_state[q.dev].ocnt, 24'd1, CNT_MAX));
			end
		end
		if (n > 0) expected_records[$].last = 1'b1;
	endtask

	// driver: presents queued requests, with a random gap after each
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_minute_records({operation, device, minute_number, cumulative_steps,
					pulse_bpm, oxygen_saturation, resident_known, resident_number});
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (pending_reqs.size() > 0) begin
					req_t q;
					q = pending_reqs.pop_front();
					{operation, device, minute_number, cumulative_steps, pulse_bpm,
						oxygen_saturation, resident_known, resident_number} <= q;
					in_valid <= 1'b1;
					in_gap <= $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random stall on the output, compares against the oldest expectation
	int out_stall = 0;
	int out_draw = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_records.size() == 0) begin
					$error("unexpected record from device %0d", out_device);
					errors++;
				end else begin
					minrec_t e;
					e = expected_records.pop_front();
					if (out_device !== e.dev) begin
						$error("out_device exp %0d got %0d", e.dev, out_device); errors++;
					end
					if (out_resident !== e.resident) begin
						$error("out_resident exp %0d got %0d", e.resident, out_resident); errors++;
					end
					if (out_minute !== e.minute) begin
						$error("out_minute exp %0d got %0d", e.minute, out_minute); errors++;
					end
					if (steps_in_minute !== e.steps) begin
						$error("steps_in_minute exp %0d got %0d", e.steps, steps_in_minute);
						errors++;
					end
					if (last_cumulative !== e.end_count) begin
						$error("last_cumulative exp %0d got %0d", e.end_count, last_cumulative);
						errors++;
					end
					if (avg_heart_rate !== e.avg_hr) begin
						$error("avg_heart_rate exp %0d got %0d", e.avg_hr, avg_heart_rate);
						errors++;
					end
					if (avg_oxygen !== e.avg_ox) begin
						$error("avg_oxygen exp %0d got %0d", e.avg_ox, avg_oxygen); errors++;
					end
					if (last !== e.last) begin
						$error("last exp %0d got %0d", e.last, last); errors++;
					end
				end
				// hold out_ready low for a random stall before taking the next record
				out_draw = $urandom_range(0, 3);
				out_ready <= (out_draw == 0);
				out_stall <= (out_draw > 0) ? out_draw - 1 : 0;
			end else if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_req(logic op, logic [3:0] d, logic [31:0] m, logic [15:0] s,
			logic [7:0] h, logic [7:0] o, logic k, logic [15:0] r);
		pending_reqs.push_back({op, d, m, s, h, o, k, r});
		queued++;
	endtask

	// waits until every request is taken and every record checked, then some slack
	task automatic drain();
		while (accepted < queued || expected_records.size() > 0) @(posedge clk);
		repeat (2000) @(posedge clk);
	endtask

	task automatic write_step_limit(logic [7:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		step_limit = v;
	endtask

	// random phase: mostly samples from any of the 16 devices ticking through minutes, some noise
	task automatic random_phase(int count);
		logic [31:0] base_minute;
		logic [15:0] cum [16];
		int d;
		base_minute = $urandom;
		for (int i = 0; i < 16; i++) cum[i] = $urandom;
		for (int i = 0; i < count; i++) begin
			d = $urandom_range(0, 15);
			case ($urandom_range(0, 19))
				0: push_req(OP_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
				1: push_req(OP_SAMPLE, d, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
				default: begin
					if ($urandom_range(0, 5) == 0) base_minute++;
					cum[d] = ($urandom_range(0, 15) == 0) ? cum[d] - $urandom_range(0, 300)
						: cum[d] + $urandom_range(0, 300);
					push_req(OP_SAMPLE, d, base_minute, cum[d],
						($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom),
						($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom),
						$urandom_range(0, 5) != 0, $urandom);
				end
			endcase
		end
		push_req(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0);
	endtask

	initial begin
		in_valid = 1'b0;
		operation = 1'b0; device = '0; minute_number = '0; cumulative_steps = '0;
		pulse_bpm = '0; oxygen_saturation = '0; resident_known = 1'b0;
		resident_number = '0; cfg_we = 1'b0; cfg_data = '0; out_ready = 1'b0;
		for (int i = 0; i < 16; i++) dev_state[i] = '0;
		step_limit = STEP_LIMIT_RESET;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, unmapped close, backward steps, flush with nothing open
		push_req(OP_FLUSH, 4'hf, '1, '1, '1, '1, 1, '1);
		push_req(OP_SAMPLE, 0, 0, 0, 0, 0, 1, 16'h0000);
		push_req(OP_SAMPLE, 0, 0, 65535, 255, 255, 0, 16'hffff);
		push_req(OP_SAMPLE, 0, 0, 10, 1, 1, 1, 5);
		push_req(OP_SAMPLE, 0, 1, 15, 0, 0, 1, 16'hffff);
		push_req(OP_SAMPLE, 15, '1, 65535, 255, 255, 1, 16'hffff);
		push_req(OP_SAMPLE, 15, '1, 0, 255, 255, 1, 1);
		push_req(OP_SAMPLE, 15, 32'h0, 100, 60, 97, 1, 2);
		push_req(OP_SAMPLE, 7, 32'h5555aaaa, 16'h5555, 8'haa, 8'h55, 0, 16'haaaa);
		push_req(OP_SAMPLE, 7, 32'haaaa5555, 16'haaaa, 8'h55, 8'haa, 1, 16'h5555);
		push_req(OP_SAMPLE, 7, 32'haaaa5555, 16'haaaa, 0, 0, 0, 0);
		push_req(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0);
		push_req(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0);
		drain();

		write_step_limit(8'd0);
		random_phase(120);
		drain();
		write_step_limit(8'd255);
		random_phase(150);
		drain();
		write_step_limit($urandom_range(1, 254));
		random_phase(160);
		drain();

		if (errors == 0 && expected_records.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
